@@ design/vdi_pkg.sv @@
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared widths and types for the vertex deduplication indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int WORD_W  = 32;
  localparam int WORDS   = 8;
  localparam int VTX_W   = WORD_W * WORDS;
  localparam int INDEX_W = 10;

  // One packed vertex: position, normal and texture words, pos_x in the low word.
  typedef logic [VTX_W-1:0] vtx_t;

endpackage

@@ design/vertex_dedup_indexer.sv @@
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Builds an index buffer by matching each vertex against the unique vertices
// stored so far in the current mesh and appending it when it is new.
// ----------------------------------------------------------------------------
// Each vertex transaction is handled one at a time. The unique vertices sit in
// one synchronous RAM of TABLE_DEPTH x 256 bits, and the search reads one entry
// per cycle from entry 0 upward, until it reaches the entry that matches or, on
// a miss, the current entry count. The single RAM read port sets this rate.
// Asserting first_of_mesh empties the table before that vertex is searched. A
// new vertex that meets a full table returns table_full with index 0 and is
// not stored.
// A finished result waits in an output register; the next vertex is accepted
// as soon as the search engine is idle.
module vertex_dedup_indexer #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_first_of_mesh,
  input  logic [vdi_pkg::WORD_W-1:0]   in_pos_x,
  input  logic [vdi_pkg::WORD_W-1:0]   in_pos_y,
  input  logic [vdi_pkg::WORD_W-1:0]   in_pos_z,
  input  logic [vdi_pkg::WORD_W-1:0]   in_norm_x,
  input  logic [vdi_pkg::WORD_W-1:0]   in_norm_y,
  input  logic [vdi_pkg::WORD_W-1:0]   in_norm_z,
  input  logic [vdi_pkg::WORD_W-1:0]   in_tex_u,
  input  logic [vdi_pkg::WORD_W-1:0]   in_tex_v,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vdi_pkg::INDEX_W-1:0]  out_vertex_index,
  output logic                         out_is_new,
  output logic                         out_table_full
);

  import vdi_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic [AW-1:0]     cmp_ptr_r, cmp_ptr_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  vtx_t              vtx_r, vtx_nxt;

  logic [INDEX_W-1:0] res_index_r, res_index_nxt;
  logic               res_new_r, res_new_nxt;
  logic               res_full_r, res_full_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic               out_new_r, out_new_nxt;
  logic               out_full_r, out_full_nxt;

  logic   ram_we;
  vtx_t   ram_rdata;
  logic   out_free;
  logic   in_fire;

  assign in_ready         = (state_r == S_IDLE);
  assign in_fire          = in_valid && in_ready;
  assign out_free         = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_index_r;
  assign out_is_new       = out_new_r;
  assign out_table_full   = out_full_r;

  // The only write happens in S_DONE, and the next search cannot start before
  // the following cycle, so reads never overlap a pending write.
  assign ram_we = (state_r == S_DONE) && out_free && res_new_r;

  vdi_ram #(
    .WIDTH  (VTX_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (vtx_r),
    .raddr (issue_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    cmp_ptr_nxt   = cmp_ptr_r;
    cmp_valid_nxt = cmp_valid_r;
    vtx_nxt       = vtx_r;
    res_index_nxt = res_index_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          vtx_nxt = {in_tex_v, in_tex_u, in_norm_z, in_norm_y,
                     in_norm_x, in_pos_z, in_pos_y, in_pos_x};
          if (in_first_of_mesh) begin
            count_nxt = '0;
          end
          issue_nxt     = '0;
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // Issue one read per cycle; the entry read last cycle is compared now.
        if (issue_r != count_r) begin
          issue_nxt     = issue_r + 1'b1;
          cmp_ptr_nxt   = issue_r[AW-1:0];
          cmp_valid_nxt = 1'b1;
        end else begin
          cmp_valid_nxt = 1'b0;
        end

        if (cmp_valid_r && (ram_rdata == vtx_r)) begin
          res_index_nxt = INDEX_W'(cmp_ptr_r);
          res_new_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_DONE;
        end else if (!cmp_valid_r && (issue_r == count_r)) begin
          if (count_r != FULL_CNT) begin
            res_index_nxt = INDEX_W'(count_r);
            res_new_nxt   = 1'b1;
            res_full_nxt  = 1'b0;
          end else begin
            res_index_nxt = '0;
            res_new_nxt   = 1'b0;
            res_full_nxt  = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_index_r;
          out_new_nxt   = res_new_r;
          out_full_nxt  = res_full_r;
          if (res_new_r) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r     <= issue_nxt;
    cmp_ptr_r   <= cmp_ptr_nxt;
    vtx_r       <= vtx_nxt;
    res_index_r <= res_index_nxt;
    res_new_r   <= res_new_nxt;
    res_full_r  <= res_full_nxt;
    out_index_r <= out_index_nxt;
    out_new_r   <= out_new_nxt;
    out_full_r  <= out_full_nxt;
  end

endmodule

@@ design/vdi_ram.sv @@
// ----------------------------------------------------------------------------
// vdi_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module vdi_ram #(
  parameter int WIDTH  = 256,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
